### design/est_pkg.sv
`default_nettype none

package est_pkg;

   localparam int KEY_W = 34;
   localparam int TAG_W = 16;

   typedef struct packed {
      logic [KEY_W-1:0] start_time;
      logic [TAG_W-1:0] tag;
   } rec_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_CMP,
      ST_PLACE,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   // control from sequencer to the result register
   typedef struct packed {
      logic valid;
      logic last_rec;
      logic overflow;
   } emit_type;

endpackage

`default_nettype wire

### design/est_store.sv
`default_nettype none

module est_store #(
   parameter int MAX_RECORDS = 32,
   parameter int AW = $clog2(MAX_RECORDS)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire est_pkg::rec_type wr_rec,
   input  wire logic [AW-1:0]    rd_addr,
   output est_pkg::rec_type      rd_rec
);

   est_pkg::rec_type mem [MAX_RECORDS];
   est_pkg::rec_type rd_rec_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_rec;
      end
      rd_rec_ff <= mem[rd_addr];
   end

   assign rd_rec = rd_rec_ff;

endmodule

`default_nettype wire

### design/est_ctrl.sv
`default_nettype none

module est_ctrl #(
   parameter int MAX_RECORDS = 32,
   parameter int AW = $clog2(MAX_RECORDS)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [est_pkg::KEY_W-1:0]    req_start_time,
   input  wire logic [est_pkg::TAG_W-1:0]    req_record_tag,
   input  wire logic                         req_batch_end,
   output logic                              busy,
   output logic                              wr_en,
   output logic [AW-1:0]                     wr_addr,
   output est_pkg::rec_type                  wr_rec,
   output logic [AW-1:0]                     rd_addr,
   input  wire est_pkg::rec_type             rd_rec,
   output est_pkg::emit_type                 emit
);

   localparam int CW = $clog2(MAX_RECORDS + 1);

   est_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      idx_ff, idx_in;
   est_pkg::rec_type   new_ff, new_in;
   logic               last_ff, last_in;

   logic key_gt;
   logic full;
   logic idx_is_last;

   // shared compare unit
   assign key_gt      = rd_rec.start_time > new_ff.start_time;
   assign full        = count_ff == CW'(MAX_RECORDS);
   assign idx_is_last = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign busy        = state_ff != est_pkg::ST_IDLE;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         est_pkg::ST_IDLE: begin
            if (start) begin
               state_in = est_pkg::ST_DECIDE;
            end
         end
         est_pkg::ST_DECIDE: begin
            if (full) begin
               state_in = last_ff ? est_pkg::ST_EMIT_RD : est_pkg::ST_IDLE;
            end else if (count_ff == '0) begin
               state_in = est_pkg::ST_PLACE;
            end else begin
               state_in = est_pkg::ST_SHIFT_RD;
            end
         end
         est_pkg::ST_SHIFT_RD: begin
            state_in = est_pkg::ST_SHIFT_CMP;
         end
         est_pkg::ST_SHIFT_CMP: begin
            if (key_gt && pos_ff != AW'(1)) begin
               state_in = est_pkg::ST_SHIFT_RD;
            end else begin
               state_in = est_pkg::ST_PLACE;
            end
         end
         est_pkg::ST_PLACE: begin
            state_in = last_ff ? est_pkg::ST_EMIT_RD : est_pkg::ST_IDLE;
         end
         est_pkg::ST_EMIT_RD: begin
            state_in = est_pkg::ST_EMIT_OUT;
         end
         est_pkg::ST_EMIT_OUT: begin
            state_in = idx_is_last ? est_pkg::ST_IDLE : est_pkg::ST_EMIT_RD;
         end
         default: begin
            state_in = est_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      new_in        = new_ff;
      last_in       = last_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_rec        = new_ff;
      rd_addr       = idx_ff;
      emit.valid    = 1'b0;
      emit.last_rec = 1'b0;
      emit.overflow = 1'b0;
      case (state_ff)
         est_pkg::ST_IDLE: begin
            if (start) begin
               new_in.start_time = req_start_time;
               new_in.tag        = req_record_tag;
               last_in           = req_batch_end;
               idx_in            = '0;
            end
         end
         est_pkg::ST_DECIDE: begin
            if (full) begin
               dropped_in = 1'b1;
            end else begin
               pos_in = AW'(count_ff);
            end
         end
         est_pkg::ST_SHIFT_RD: begin
            rd_addr = pos_ff - AW'(1);
         end
         est_pkg::ST_SHIFT_CMP: begin
            if (key_gt) begin
               // move the later record up one slot
               wr_en  = 1'b1;
               wr_rec = rd_rec;
               pos_in = pos_ff - AW'(1);
            end
         end
         est_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
         est_pkg::ST_EMIT_RD: begin
            rd_addr = idx_ff;
         end
         est_pkg::ST_EMIT_OUT: begin
            emit.valid    = 1'b1;
            emit.last_rec = idx_is_last;
            emit.overflow = idx_is_last && dropped_ff;
            if (idx_is_last) begin
               count_in   = '0;
               dropped_in = 1'b0;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= est_pkg::ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      new_ff  <= new_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

### design/event_insertion_sorter_top.sv
// Stable insertion sorter for records of a 34-bit start time and a 16-bit tag. A transaction
// is accepted when start is high and busy is low; busy then stays high until that record is
// placed in the record memory. Each stored record that is looked at costs a memory read and
// a compare-and-write through the single memory port pair. A record that arrives while
// MAX_RECORDS are held is dropped. The transaction with req_batch_end set inserts its record
// and then, with busy still high, streams the whole store out in ascending start order,
// equal start times in arrival order, each result shown for exactly one cycle on rsp_valid,
// the last one in the same cycle that busy falls; the receiver cannot stall, so it must take
// every result as it comes. rsp_final_record marks the last result, and rsp_overflow_seen on
// it reports dropped records. The memory is not cleared after reset; only written entries are
// ever read.
`default_nettype none

module event_insertion_sorter_top #(
   parameter int MAX_RECORDS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [est_pkg::KEY_W-1:0] req_start_time,
   input  wire logic [est_pkg::TAG_W-1:0] req_record_tag,
   input  wire logic                      req_batch_end,
   output logic                           rsp_valid,
   output logic [est_pkg::KEY_W-1:0]      rsp_sorted_start,
   output logic [est_pkg::TAG_W-1:0]      rsp_sorted_tag,
   output logic                           rsp_final_record,
   output logic                           rsp_overflow_seen
);

   localparam int AW = $clog2(MAX_RECORDS);

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   est_pkg::rec_type  wr_rec;
   logic [AW-1:0]     rd_addr;
   est_pkg::rec_type  rd_rec;
   est_pkg::emit_type emit;

   logic                      rsp_valid_ff;
   logic                      rsp_final_ff;
   logic                      rsp_overflow_ff;
   logic [est_pkg::KEY_W-1:0] rsp_start_ff;
   logic [est_pkg::TAG_W-1:0] rsp_tag_ff;

   est_ctrl #(
      .MAX_RECORDS(MAX_RECORDS),
      .AW(AW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_start_time(req_start_time),
      .req_record_tag(req_record_tag),
      .req_batch_end(req_batch_end),
      .busy(busy),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_rec(wr_rec),
      .rd_addr(rd_addr),
      .rd_rec(rd_rec),
      .emit(emit)
   );

   est_store #(
      .MAX_RECORDS(MAX_RECORDS),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_rec(wr_rec),
      .rd_addr(rd_addr),
      .rd_rec(rd_rec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit.valid;
      end
      if (emit.valid) begin
         rsp_start_ff    <= rd_rec.start_time;
         rsp_tag_ff      <= rd_rec.tag;
         rsp_final_ff    <= emit.last_rec;
         rsp_overflow_ff <= emit.overflow;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sorted_start  = rsp_start_ff;
   assign rsp_sorted_tag    = rsp_tag_ff;
   assign rsp_final_record  = rsp_final_ff;
   assign rsp_overflow_seen = rsp_overflow_ff;

endmodule

`default_nettype wire

### design/est_checker.sv
`default_nettype none

module est_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_final_record,
   input wire logic rsp_overflow_seen
);

   // an accepted transaction always occupies the sequencer
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted transaction");

   // overflow is only reported on the final result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_seen |-> rsp_final_record)
      else $error("overflow flag outside final result");

   // more results follow, so the block must stay busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_record |=> busy)
      else $error("block went idle in the middle of a sorted run");

   // results come from the sequencer, never from an idle block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without prior activity");

endmodule

bind event_insertion_sorter_top est_checker u_est_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_final_record(rsp_final_record),
   .rsp_overflow_seen(rsp_overflow_seen)
);

`default_nettype wire
